// File: hw/rtl/sspq_pkg.sv
// Shared types and codes of the stable sorted priority queue.
package sspq_pkg;

	localparam logic       FUNC_ENQ = 1'b0;
	localparam logic       FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} slot_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		logic  enq;
		logic  deq;
		slot_t slot;
	} cell_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               head_valid;
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
		logic [4:0]         entry_count;
	} result_t;

endpackage

// File: hw/rtl/sspq_cell.sv
// One slot of the shift-register queue: compare, hold, shift in from a neighbor.
module sspq_cell import sspq_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] count,
	input  slot_t            left_slot,
	input  logic             left_ge,
	input  slot_t            right_slot,
	output slot_t            slot,
	output slot_t            slot_nxt,
	output logic             ge
);

	slot_t slot_q;
	logic  occupied;

	assign occupied = count > CNT_W'(IDX);
	// Stored entry stays ahead of an incoming one of equal priority
	assign ge       = occupied && (slot_q.prio >= cmd.slot.prio);
	assign slot     = slot_q;

	always_comb begin
		slot_nxt = slot_q;
		if (cmd.enq) begin
			if (!ge) begin
				slot_nxt = left_ge ? cmd.slot : left_slot;
			end
		end else if (cmd.deq) begin
			slot_nxt = right_slot;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_nxt;
	end

endmodule

// File: hw/rtl/sspq_out_buf.sv
// Two-entry output buffer: output register plus skid register.
module sspq_out_buf import sspq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// File: hw/rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: cell chain, count and result buffer.
//
//   channel | handshake           | beat
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | func, item_value, item_priority
//   out     | out_valid/out_stall | status, head_valid, head_value,
//           |                     | head_priority, entry_count
//
// One beat per cycle in while in_stall is low; its result is registered in the output
// register, or in the skid register while out is stalled. All DEPTH cells compare
// against the new priority in parallel and shift in the same cycle as acceptance.
// Reset clears the count and buffer valids; slot contents are not reset.
// in_stall rises only when both output registers hold results.
module stable_sorted_priority_queue import sspq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [31:0] item_value,
	input  logic signed [31:0] item_priority,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               head_valid,
	output logic signed [31:0] head_value,
	output logic signed [31:0] head_priority,
	output logic [4:0]         entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = CNT_W + 5;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [EXT_W-1:0] count_ext;
	logic             accept;
	logic             full;
	logic             empty;
	logic             buf_full;
	cell_cmd_t        cmd;
	result_t          res;
	result_t          out_data;

	slot_t cell_slot [DEPTH];
	slot_t cell_nxt  [DEPTH];
	logic  cell_ge   [DEPTH];

	assign accept        = in_valid && !buf_full;
	assign in_stall      = buf_full;
	assign full          = count_q == CNT_W'(DEPTH);
	assign empty         = count_q == '0;

	assign cmd.enq       = accept && (func == FUNC_ENQ) && !full;
	assign cmd.deq       = accept && (func == FUNC_DEQ) && !empty;
	assign cmd.slot      = '{value: item_value, prio: item_priority};

	always_comb begin
		count_nxt = count_q;
		if (cmd.enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.deq) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_slot;
		logic  left_ge;
		slot_t right_slot;

		if (i == 0) begin : g_first
			assign left_slot = cmd.slot;
			assign left_ge   = 1'b1;
		end else begin : g_mid
			assign left_slot = cell_slot[i-1];
			assign left_ge   = cell_ge[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_slot = cell_slot[i];
		end else begin : g_inner
			assign right_slot = cell_slot[i+1];
		end

		sspq_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_slot  (left_slot),
			.left_ge    (left_ge),
			.right_slot (right_slot),
			.slot       (cell_slot[i]),
			.slot_nxt   (cell_nxt[i]),
			.ge         (cell_ge[i])
		);
	end

	assign count_ext = EXT_W'(count_nxt);

	always_comb begin
		res.status = ST_DONE;
		if (func == FUNC_ENQ && full) begin
			res.status = ST_FULL;
		end else if (func == FUNC_DEQ && empty) begin
			res.status = ST_EMPTY;
		end
		res.head_valid    = count_nxt != '0;
		// Report zero for an empty store
		res.head_value    = res.head_valid ? cell_nxt[0].value : '0;
		res.head_priority = res.head_valid ? cell_nxt[0].prio : '0;
		res.entry_count   = count_ext[4:0];
	end

	sspq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status        = out_data.status;
	assign head_valid    = out_data.head_valid;
	assign head_value    = out_data.head_value;
	assign head_priority = out_data.head_priority;
	assign entry_count   = out_data.entry_count;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_slot[0].prio >= cell_slot[1].prio))
		else $error("head and second slot out of priority order");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_ENQ) && full) |=> (count_q == $past(count_q)))
		else $error("refused enqueue changed the count");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("enqueue did not grow the count");

endmodule
